/* hw/rtl/cca_pkg.sv */
`timescale 1ns / 1ps

package cca_pkg;

  localparam int SLOTS_DEFAULT = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [23:0] COLLISION_RANGE_RESET = 24'd1024;

  localparam logic [CFG_INDEX_W-1:0] REG_COLLISION_RANGE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRASH_EVENTS_ENABLE = 2'd1;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] MUL1_FIRST = 5'd0;
  localparam logic [OP_W-1:0] MUL1_LAST = 5'd9;
  localparam logic [OP_W-1:0] MUL2_FIRST = 5'd10;
  localparam logic [OP_W-1:0] MUL2_LAST = 5'd21;

  typedef struct packed {
    logic [31:0] last_range;
    logic        rate_neg;
    logic [1:0]  pass;
    logic        coll;
    logic [31:0] distance;
  } entry_t;

  typedef enum logic [3:0] {
    SRC_PX, SRC_PY, SRC_PZ, SRC_VX, SRC_VY, SRC_VZ, SRC_CR,
    SRC_PSQ_LO, SRC_PSQ_HI, SRC_VSQ_LO, SRC_VSQ_HI,
    SRC_DOT_LO, SRC_DOT_HI, SRC_CR2_LO, SRC_CR2_HI
  } src_t;

  typedef enum logic [2:0] {
    DST_PSQ, DST_VSQ, DST_DOT, DST_CR2, DST_SV, DST_DD, DST_THR
  } dest_t;

  typedef struct packed {
    src_t       a;
    src_t       b;
    logic [1:0] shift;
    dest_t      dest;
  } uop_t;

  function automatic uop_t mk(src_t a, src_t b, logic [1:0] sh, dest_t d);
    uop_t u;
    u.a = a;
    u.b = b;
    u.shift = sh;
    u.dest = d;
    return u;
  endfunction

  function automatic uop_t uop_of(logic [OP_W-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = mk(SRC_PX, SRC_PX, 2'd0, DST_PSQ);
      5'd1:    u = mk(SRC_PY, SRC_PY, 2'd0, DST_PSQ);
      5'd2:    u = mk(SRC_PZ, SRC_PZ, 2'd0, DST_PSQ);
      5'd3:    u = mk(SRC_VX, SRC_VX, 2'd0, DST_VSQ);
      5'd4:    u = mk(SRC_VY, SRC_VY, 2'd0, DST_VSQ);
      5'd5:    u = mk(SRC_VZ, SRC_VZ, 2'd0, DST_VSQ);
      5'd6:    u = mk(SRC_PX, SRC_VX, 2'd0, DST_DOT);
      5'd7:    u = mk(SRC_PY, SRC_VY, 2'd0, DST_DOT);
      5'd8:    u = mk(SRC_PZ, SRC_VZ, 2'd0, DST_DOT);
      5'd9:    u = mk(SRC_CR, SRC_CR, 2'd0, DST_CR2);
      5'd10:   u = mk(SRC_PSQ_LO, SRC_VSQ_LO, 2'd0, DST_SV);
      5'd11:   u = mk(SRC_PSQ_LO, SRC_VSQ_HI, 2'd1, DST_SV);
      5'd12:   u = mk(SRC_PSQ_HI, SRC_VSQ_LO, 2'd1, DST_SV);
      5'd13:   u = mk(SRC_PSQ_HI, SRC_VSQ_HI, 2'd2, DST_SV);
      5'd14:   u = mk(SRC_DOT_LO, SRC_DOT_LO, 2'd0, DST_DD);
      5'd15:   u = mk(SRC_DOT_LO, SRC_DOT_HI, 2'd1, DST_DD);
      5'd16:   u = mk(SRC_DOT_HI, SRC_DOT_LO, 2'd1, DST_DD);
      5'd17:   u = mk(SRC_DOT_HI, SRC_DOT_HI, 2'd2, DST_DD);
      5'd18:   u = mk(SRC_CR2_LO, SRC_VSQ_LO, 2'd0, DST_THR);
      5'd19:   u = mk(SRC_CR2_LO, SRC_VSQ_HI, 2'd1, DST_THR);
      5'd20:   u = mk(SRC_CR2_HI, SRC_VSQ_LO, 2'd1, DST_THR);
      5'd21:   u = mk(SRC_CR2_HI, SRC_VSQ_HI, 2'd2, DST_THR);
      default: u = mk(SRC_CR, SRC_CR, 2'd0, DST_CR2);
    endcase
    return u;
  endfunction

endpackage

/* hw/rtl/cca_ram.sv */
`timescale 1ns / 1ps

module cca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/closest_approach_collision_check.sv */
`timescale 1ns / 1ps

// Channel   Direction  Transfers
// s_axis    in         one target slot transaction: slot, flags, step time, position, velocity
// m_axis    out        one result transaction per input transaction
// cfg       in         register write: index and data
//
// A checked item first forms products on the shared 32 by 32 multiplier and takes a square root
// of the range, and the range test may decide there; otherwise the closest approach is
// interpolated with further products, and if it is within range a divider and a second
// square root give the hit distance. A skipped item goes straight to the write. The square
// root yields one bit a cycle and is used once or twice; the divider yields one bit a cycle.
// After reset a clearing pass writes every slot of the state memory, during which no item
// is taken; configuration writes are taken at all times.
// A result waits in the output register while the next item is already being worked on;
// the block holds its write cycle until that register is free.

module closest_approach_collision_check #(
  parameter int SLOTS = cca_pkg::SLOTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // slot[4:0], step_time[20:5], rel_pos_x[52:21], rel_pos_y[84:53], rel_pos_z[116:85],
  // rel_vel_x[140:117], rel_vel_y[164:141], rel_vel_z[188:165], zero[191:189]
  input  logic [191:0]                     s_tdata,
  // restart[0], target_active[1]
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // slot_out[4:0], collided[5], hit_distance[37:6], crash flag[38], zero[39]
  output logic [39:0]                      m_tdata,
  // checked[0]
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cca_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import cca_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $bits(entry_t);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_READ   = 13'b0000000000100,
    S_MUL1   = 13'b0000000001000,
    S_SQRT_R = 13'b0000000010000,
    S_DECIDE = 13'b0000000100000,
    S_MUL2   = 13'b0000001000000,
    S_NUM    = 13'b0000010000000,
    S_CMP    = 13'b0000100000000,
    S_DIV    = 13'b0001000000000,
    S_SQRT_D = 13'b0010000000000,
    S_UPDATE = 13'b0100000000000,
    S_WRITE  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [23:0] crange;
  logic        crash_en;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic [4:0]    slot;
  logic          restart;
  logic          oor;
  logic          skip;
  logic [31:0]   pmag [3];
  logic [2:0]    pneg;
  logic [23:0]   vmag [3];
  logic [2:0]    vneg;

  entry_t rec;
  entry_t rdata_e;
  logic [EW-1:0] ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;

  logic [OP_W-1:0]   mstep;
  uop_t              u;
  logic [31:0]       a_val;
  logic [31:0]       b_val;
  logic              a_sign;
  logic              issuing;
  logic [63:0]       prod;
  logic [1:0]        prod_shift;
  logic              prod_neg;
  dest_t             prod_dest;
  logic              prod_vld;
  logic [127:0]      term;

  logic [63:0]         psq;
  logic [63:0]         vsq;
  logic signed [63:0]  dot;
  logic [63:0]         dmag;
  logic [63:0]         cr2;
  logic [127:0]        sv;
  logic [127:0]        dd;
  logic [127:0]        thr;
  logic [127:0]        num;
  logic [31:0]         range;
  logic [31:0]         cpa_dist;
  logic                col;
  logic                checked;
  logic                crash;

  logic [5:0]  iter;
  logic [63:0] sq_val;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [35:0] sq_rem_sh;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [33:0] sq_rem_next;
  logic [31:0] sq_root_next;

  logic [47:0] div_rem;
  logic [63:0] div_n;
  logic [63:0] div_q;
  logic [48:0] div_r2;
  logic        div_ge;
  logic [47:0] div_rem_next;

  logic        out_load;
  logic [4:0]  out_slot;
  logic        out_checked;
  logic        out_coll;
  logic [31:0] out_dist;
  logic        out_crash;

  logic        s_accept;
  logic [4:0]  in_slot;

  assign in_slot  = s_tdata[4:0];
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign rdata_e   = entry_t'(ram_rdata);
  assign ram_raddr = AW'(in_slot);
  assign ram_we    = (state == S_CLEAR) || ((state == S_WRITE) && !oor);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 : EW'(rec);

  cca_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign dmag = dot[63] ? 64'(-dot) : 64'(dot);
  assign u = uop_of(mstep);
  assign issuing = ((state == S_MUL1) && (mstep <= MUL1_LAST)) ||
                   ((state == S_MUL2) && (mstep <= MUL2_LAST));

  function automatic logic [31:0] src_val(src_t s, logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [23:0] vx,
                                          logic [23:0] vy, logic [23:0] vz,
                                          logic [23:0] cr, logic [63:0] ps,
                                          logic [63:0] vs, logic [63:0] dm,
                                          logic [63:0] c2);
    logic [31:0] r;
    case (s)
      SRC_PX:     r = px;
      SRC_PY:     r = py;
      SRC_PZ:     r = pz;
      SRC_VX:     r = {8'b0, vx};
      SRC_VY:     r = {8'b0, vy};
      SRC_VZ:     r = {8'b0, vz};
      SRC_CR:     r = {8'b0, cr};
      SRC_PSQ_LO: r = ps[31:0];
      SRC_PSQ_HI: r = ps[63:32];
      SRC_VSQ_LO: r = vs[31:0];
      SRC_VSQ_HI: r = vs[63:32];
      SRC_DOT_LO: r = dm[31:0];
      SRC_DOT_HI: r = dm[63:32];
      SRC_CR2_LO: r = c2[31:0];
      SRC_CR2_HI: r = c2[63:32];
      default:    r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    a_val = src_val(u.a, pmag[0], pmag[1], pmag[2], vmag[0], vmag[1], vmag[2],
                    crange, psq, vsq, dmag, cr2);
    b_val = src_val(u.b, pmag[0], pmag[1], pmag[2], vmag[0], vmag[1], vmag[2],
                    crange, psq, vsq, dmag, cr2);
    case (u.a)
      SRC_PX:  a_sign = pneg[0] ^ vneg[0];
      SRC_PY:  a_sign = pneg[1] ^ vneg[1];
      SRC_PZ:  a_sign = pneg[2] ^ vneg[2];
      default: a_sign = 1'b0;
    endcase
  end

  assign term = 128'(prod) << {prod_shift, 5'b0};

  always_comb begin
    sq_rem_sh = {sq_rem, sq_val[63:62]};
    sq_trial  = {2'b00, sq_root, 2'b01};
    sq_ge     = (sq_rem_sh >= sq_trial);
    sq_rem_next  = sq_ge ? 34'(sq_rem_sh - sq_trial) : sq_rem_sh[33:0];
    sq_root_next = {sq_root[30:0], sq_ge};
    div_r2 = {div_rem, div_n[63]};
    div_ge = (div_r2 >= {1'b0, vsq[47:0]});
    div_rem_next = div_ge ? 48'(div_r2 - {1'b0, vsq[47:0]}) : div_r2[47:0];
  end

  assign out_load = (state == S_WRITE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      crange   <= COLLISION_RANGE_RESET;
      crash_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COLLISION_RANGE) begin
        crange <= cfg_data[23:0];
      end
      if (cfg_index == REG_CRASH_EVENTS_ENABLE) begin
        crash_en <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod       <= a_val * b_val;
    prod_shift <= u.shift;
    prod_neg   <= a_sign;
    prod_dest  <= u.dest;
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= issuing;
    end
    if (prod_vld) begin
      case (prod_dest)
        DST_PSQ: psq <= psq + term[63:0];
        DST_VSQ: vsq <= vsq + term[63:0];
        DST_DOT: dot <= prod_neg ? dot - $signed(term[63:0]) : dot + $signed(term[63:0]);
        DST_CR2: cr2 <= cr2 + term[63:0];
        DST_SV:  sv  <= sv + term;
        DST_DD:  dd  <= dd + term;
        DST_THR: thr <= thr + term;
        default: ;
      endcase
    end
    if (state == S_READ) begin
      psq <= '0;
      vsq <= '0;
      dot <= '0;
      cr2 <= '0;
    end
    if (state == S_DECIDE) begin
      sv  <= '0;
      dd  <= '0;
      thr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (oor || skip) begin
            state <= S_WRITE;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mstep == MUL1_LAST + 1'b1) begin
            state <= S_SQRT_R;
          end
        end
        S_SQRT_R: begin
          if (iter == 6'd31) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (psq <= cr2) begin
            state <= S_UPDATE;
          end else if (rec.rate_neg && (sq_root >= rec.last_range) &&
                       (rec.pass == 2'd2) && (vsq != '0)) begin
            state <= S_MUL2;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_MUL2: begin
          if (mstep == MUL2_LAST + 1'b1) begin
            state <= S_NUM;
          end
        end
        S_NUM: state <= S_CMP;
        S_CMP: begin
          if (num <= thr) begin
            state <= S_DIV;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_DIV: begin
          if (iter == 6'd63) begin
            state <= S_SQRT_D;
          end
        end
        S_SQRT_D: begin
          if (iter == 6'd31) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: state <= S_WRITE;
        S_WRITE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          slot    <= in_slot;
          addr    <= AW'(in_slot);
          oor     <= ({27'b0, in_slot} >= 32'(SLOTS));
          restart <= s_tuser[0];
          skip    <= !s_tuser[1] || (s_tdata[20:5] == 16'd0);
          for (int i = 0; i < 3; i++) begin
            pneg[i] <= s_tdata[52 + 32*i];
            pmag[i] <= s_tdata[52 + 32*i] ? 32'(-s_tdata[21 + 32*i +: 32])
                                          : s_tdata[21 + 32*i +: 32];
            vneg[i] <= s_tdata[140 + 24*i];
            vmag[i] <= s_tdata[140 + 24*i] ? 24'(-s_tdata[117 + 24*i +: 24])
                                           : s_tdata[117 + 24*i +: 24];
          end
        end
      end
      S_READ: begin
        rec     <= restart ? '0 : rdata_e;
        mstep   <= MUL1_FIRST;
        col     <= 1'b0;
        checked <= 1'b0;
        crash   <= 1'b0;
      end
      S_MUL1: begin
        mstep <= mstep + 1'b1;
        if (mstep == MUL1_LAST + 1'b1) begin
          sq_val  <= psq + ((prod_vld && prod_dest == DST_PSQ) ? term[63:0] : 64'd0);
          sq_rem  <= '0;
          sq_root <= '0;
          iter    <= '0;
        end
      end
      S_SQRT_R, S_SQRT_D: begin
        sq_val  <= {sq_val[61:0], 2'b00};
        sq_rem  <= sq_rem_next;
        sq_root <= sq_root_next;
        iter    <= iter + 1'b1;
        if (state == S_SQRT_D && iter == 6'd31) begin
          cpa_dist <= sq_root_next;
          col      <= 1'b1;
        end
      end
      S_DECIDE: begin
        range <= sq_root;
        mstep <= MUL2_FIRST;
        if (psq <= cr2) begin
          col      <= 1'b1;
          cpa_dist <= sq_root;
        end
      end
      S_MUL2: mstep <= mstep + 1'b1;
      S_NUM: num <= (dd <= sv) ? sv - dd : '0;
      S_CMP: begin
        div_rem <= num[111:64];
        div_n   <= num[63:0];
        div_q   <= '0;
        iter    <= '0;
      end
      S_DIV: begin
        div_rem <= div_rem_next;
        div_n   <= {div_n[62:0], 1'b0};
        div_q   <= {div_q[62:0], div_ge};
        if (iter == 6'd63) begin
          sq_val  <= {div_q[62:0], div_ge};
          sq_rem  <= '0;
          sq_root <= '0;
          iter    <= '0;
        end else begin
          iter    <= iter + 1'b1;
        end
      end
      S_UPDATE: begin
        rec.coll       <= col;
        rec.distance   <= col ? cpa_dist : rec.distance;
        rec.rate_neg   <= (range < rec.last_range);
        rec.last_range <= range;
        rec.pass       <= (rec.pass == 2'd2) ? 2'd2 : rec.pass + 1'b1;
        checked        <= 1'b1;
        crash          <= col && crash_en;
      end
      S_WRITE: begin
        if (out_load) begin
          out_slot    <= slot;
          out_checked <= checked && !oor;
          out_coll    <= oor ? 1'b0 : rec.coll;
          out_dist    <= oor ? 32'd0 : rec.distance;
          out_crash   <= crash && !oor;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {1'b0, out_crash, out_dist, out_coll, out_slot};
  assign m_tuser = out_checked;

endmodule
